// ===== rtl/srtq_pkg.sv =====
// Shared constants and types of the sorted timer queue.
`default_nettype none
package srtq_pkg;

   // timer slots built; slot field can address at most SLOT_SPACE of them
   localparam int NUM_TIMERS = 16;
   localparam int SLOT_SPACE = 16;
   localparam int SLOTS      = (NUM_TIMERS < SLOT_SPACE) ? NUM_TIMERS : SLOT_SPACE;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 64;

   // operation codes
   localparam logic [1:0] OP_ADVANCE = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_STOP    = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   // command to the sorted list
   typedef struct packed {
      logic             unlink;
      logic             insert;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] pos;
   } order_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/srtq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module srtq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/srtq_order.sv =====
// Alarm-ordered list of armed slots: unlink by slot, insert at a position.
`default_nettype none
module srtq_order (
   input  logic                          clock,
   input  logic                          reset,
   input  srtq_pkg::order_cmd_type       cmd,
   input  logic [srtq_pkg::IDX_W-1:0]    rd_pos,
   output logic [srtq_pkg::IDX_W-1:0]    rd_entry,
   output logic [srtq_pkg::IDX_W-1:0]    head,
   output logic [srtq_pkg::CNT_W-1:0]    count
);
   import srtq_pkg::*;

   logic [IDX_W-1:0] order_ff [SLOTS];
   logic [IDX_W-1:0] order_in [SLOTS];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             seen;

   always_comb begin
      seen     = 1'b0;
      count_in = count_ff;
      for (int i = 0; i < SLOTS; i++) begin
         order_in[i] = order_ff[i];
      end
      if (cmd.unlink) begin
         // close the gap left by the matching entry
         for (int i = 0; i < SLOTS; i++) begin
            if (CNT_W'(i) < count_ff && order_ff[i] == cmd.slot) begin
               seen = 1'b1;
            end
            if (seen && i < SLOTS - 1) begin
               order_in[i] = order_ff[i+1];
            end
         end
         if (seen) begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (cmd.insert && count_ff < CNT_W'(SLOTS)) begin
         // open a gap at pos and drop the slot in
         for (int j = 0; j < SLOTS; j++) begin
            if (j > 0 && CNT_W'(j) > cmd.pos) begin
               order_in[j] = order_ff[j-1];
            end else if (CNT_W'(j) == cmd.pos) begin
               order_in[j] = cmd.slot;
            end
         end
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < SLOTS; i++) begin
         order_ff[i] <= order_in[i];
      end
   end

   assign rd_entry = order_ff[rd_pos];
   assign head     = order_ff[0];
   assign count    = count_ff;

endmodule
`default_nettype wire

// ===== rtl/sorted_software_timer_queue_unit.sv =====
// Top level of the sorted timer queue: sequencer, counter, alarm and timeout RAMs.
//
//  channel | dir | handshake              | payload
//  req_    | in  | req_tvalid/req_tready  | tuser opcode; tdata slot, amount, repeat_mode
//  rsp_    | out | rsp_tvalid/rsp_tready  | tuser kind; tdata slot, now, until; tlast
//
// One word at a time. Start: accept, then the ordered walk over the alarm RAM,
// then the head read, then the reply. Advance: a head read and compare per due
// timer, plus a walk per re-armed timer, then one word per expiry. The walk
// goes through the single alarm RAM read port.
// Synchronous reset clears counter, flags and list count; RAMs are not cleared.
// A stalled rsp_ holds the sequencer; req_tready is high only when idle.
`default_nettype none
module sorted_software_timer_queue_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // opcode
   input  logic [71:0]  req_tdata,   // slot[3:0], amount[67:4], repeat_mode[68], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,   // kind
   output logic [135:0] rsp_tdata,   // expired_slot[3:0], now_us[67:4], until_next[131:68]
   output logic         rsp_tlast
);
   import srtq_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ADV_RD    = 4'd1;
   localparam logic [3:0] S_ADV_CMP   = 4'd2;
   localparam logic [3:0] S_REARM     = 4'd3;
   localparam logic [3:0] S_REARM_ADD = 4'd4;
   localparam logic [3:0] S_LINK      = 4'd5;
   localparam logic [3:0] S_HEAD      = 4'd6;
   localparam logic [3:0] S_HEAD_CMP  = 4'd7;
   localparam logic [3:0] S_EMIT      = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TIME_W-1:0] counter_ff, counter_in;
   logic [TIME_W-1:0] alarm_ff, alarm_in;
   logic [TIME_W-1:0] until_ff, until_in;
   logic [IDX_W-1:0]  lk_slot_ff, lk_slot_in;
   logic [CNT_W-1:0]  lk_i_ff, lk_i_in;
   logic              lk_pend_ff, lk_pend_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  e_ff, e_in;
   logic [IDX_W-1:0]  due_ff [SLOTS];
   logic [IDX_W-1:0]  due_in [SLOTS];
   logic [SLOTS-1:0]  armed_ff, armed_in;
   logic [SLOTS-1:0]  repeat_ff, repeat_in;

   // request fields
   logic [SLOT_W-1:0] req_slot;
   logic [TIME_W-1:0] req_amount;
   logic              req_repeat;
   logic              req_fire;
   logic              slot_ok;
   logic [IDX_W-1:0]  slot_idx;

   // list and RAM hookup
   order_cmd_type     ocmd;
   logic [IDX_W-1:0]  o_entry, o_head;
   logic [CNT_W-1:0]  o_count;
   logic              a_we, t_we;
   logic [IDX_W-1:0]  a_waddr, a_raddr, t_raddr, rearm_slot;
   logic [TIME_W-1:0] a_wdata, a_rdata, t_rdata;
   logic [TIME_W-1:0] sum;
   logic              last_word;

   assign req_slot   = req_tdata[3:0];
   assign req_amount = req_tdata[67:4];
   assign req_repeat = req_tdata[68];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_ok    = {1'b0, req_slot} < 5'(SLOTS);
   assign slot_idx   = req_slot[IDX_W-1:0];
   assign rearm_slot = due_ff[k_ff[IDX_W-1:0]];

   // one adder: counter plus request amount or stored timeout
   assign sum = counter_ff + ((state_ff == S_IDLE) ? req_amount : t_rdata);

   srtq_order u_order (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ocmd),
      .rd_pos   (lk_i_ff[IDX_W-1:0]),
      .rd_entry (o_entry),
      .head     (o_head),
      .count    (o_count)
   );

   srtq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_alarm_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   srtq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_timeout_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (slot_idx),
      .wr_data (req_amount),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   assign a_raddr = (state_ff == S_LINK) ? o_entry : o_head;
   assign t_raddr = rearm_slot;
   assign a_wdata = sum;

   // output word
   assign last_word  = (op_ff != OP_ADVANCE) || (e_ff == n_ff - CNT_W'(1));
   assign rsp_tvalid = (state_ff == S_EMIT);
   assign rsp_tuser  = (op_ff != OP_ADVANCE);
   assign rsp_tlast  = last_word;
   always_comb begin
      logic [SLOT_W-1:0] out_slot;
      unique case (op_ff)
         OP_ADVANCE: out_slot = SLOT_W'(due_ff[e_ff[IDX_W-1:0]]);
         OP_QUERY:   out_slot = '0;
         default:    out_slot = slot_ff;
      endcase
      rsp_tdata = {4'b0, until_ff, counter_ff, out_slot};
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      slot_in    = slot_ff;
      counter_in = counter_ff;
      alarm_in   = alarm_ff;
      until_in   = until_ff;
      lk_slot_in = lk_slot_ff;
      lk_i_in    = lk_i_ff;
      lk_pend_in = lk_pend_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      e_in       = e_ff;
      armed_in   = armed_ff;
      repeat_in  = repeat_ff;
      for (int i = 0; i < SLOTS; i++) begin
         due_in[i] = due_ff[i];
      end
      ocmd       = '0;
      a_we       = 1'b0;
      a_waddr    = lk_slot_ff;
      t_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser;
               slot_in = req_slot;
               e_in    = '0;
               unique case (req_tuser)
                  OP_ADVANCE: begin
                     counter_in = sum;
                     n_in       = '0;
                     state_in   = S_ADV_RD;
                  end
                  OP_START: begin
                     state_in = S_HEAD;
                     if (slot_ok) begin
                        if (armed_ff[slot_idx]) begin
                           ocmd.unlink        = 1'b1;
                           ocmd.slot          = slot_idx;
                           armed_in[slot_idx] = 1'b0;
                        end
                        repeat_in[slot_idx] = req_repeat;
                        t_we       = 1'b1;
                        a_we       = 1'b1;
                        a_waddr    = slot_idx;
                        alarm_in   = sum;
                        lk_slot_in = slot_idx;
                        lk_i_in    = '0;
                        lk_pend_in = 1'b0;
                        state_in   = S_LINK;
                     end
                  end
                  OP_STOP: begin
                     state_in = S_HEAD;
                     if (slot_ok) begin
                        repeat_in[slot_idx] = 1'b0;
                        if (armed_ff[slot_idx]) begin
                           ocmd.unlink        = 1'b1;
                           ocmd.slot          = slot_idx;
                           armed_in[slot_idx] = 1'b0;
                        end
                     end
                  end
                  default: state_in = S_HEAD;
               endcase
            end
         end

         // pull due timers off the head
         S_ADV_RD: begin
            if (o_count == '0) begin
               k_in     = '0;
               state_in = S_REARM;
            end else begin
               state_in = S_ADV_CMP;
            end
         end
         S_ADV_CMP: begin
            if (a_rdata <= counter_ff) begin
               due_in[n_ff[IDX_W-1:0]] = o_head;
               n_in              = n_ff + CNT_W'(1);
               ocmd.unlink       = 1'b1;
               ocmd.slot         = o_head;
               armed_in[o_head]  = 1'b0;
               state_in          = S_ADV_RD;
            end else begin
               k_in     = '0;
               state_in = S_REARM;
            end
         end

         // re-arm repeating timers in expiry order
         S_REARM: begin
            if (k_ff == n_ff) begin
               state_in = (n_ff == '0) ? S_IDLE : S_HEAD;
            end else if (repeat_ff[rearm_slot]) begin
               state_in = S_REARM_ADD;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         S_REARM_ADD: begin
            a_we       = 1'b1;
            a_waddr    = rearm_slot;
            alarm_in   = sum;
            lk_slot_in = rearm_slot;
            lk_i_in    = '0;
            lk_pend_in = 1'b0;
            k_in       = k_ff + CNT_W'(1);
            state_in   = S_LINK;
         end

         // ordered walk: issue read of entry i, compare entry i-1
         S_LINK: begin
            if (lk_pend_ff && a_rdata > alarm_ff) begin
               ocmd.insert          = 1'b1;
               ocmd.slot            = lk_slot_ff;
               ocmd.pos             = lk_i_ff - CNT_W'(1);
               armed_in[lk_slot_ff] = 1'b1;
               state_in = (op_ff == OP_ADVANCE) ? S_REARM : S_HEAD;
            end else if (lk_i_ff == o_count) begin
               if (o_count < CNT_W'(SLOTS)) begin
                  ocmd.insert          = 1'b1;
                  ocmd.slot            = lk_slot_ff;
                  ocmd.pos             = o_count;
                  armed_in[lk_slot_ff] = 1'b1;
               end
               state_in = (op_ff == OP_ADVANCE) ? S_REARM : S_HEAD;
            end else begin
               lk_i_in    = lk_i_ff + CNT_W'(1);
               lk_pend_in = 1'b1;
            end
         end

         // time to head alarm
         S_HEAD: begin
            if (o_count == '0) begin
               until_in = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_HEAD_CMP;
            end
         end
         S_HEAD_CMP: begin
            until_in = (a_rdata <= counter_ff) ? '0 : a_rdata - counter_ff;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (rsp_tready) begin
               if (last_word) begin
                  state_in = S_IDLE;
               end else begin
                  e_in = e_ff + CNT_W'(1);
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         counter_ff <= '0;
         armed_ff   <= '0;
         repeat_ff  <= '0;
         lk_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         counter_ff <= counter_in;
         armed_ff   <= armed_in;
         repeat_ff  <= repeat_in;
         lk_pend_ff <= lk_pend_in;
      end
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      alarm_ff   <= alarm_in;
      until_ff   <= until_in;
      lk_slot_ff <= lk_slot_in;
      lk_i_ff    <= lk_i_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      e_ff       <= e_in;
      for (int i = 0; i < SLOTS; i++) begin
         due_ff[i] <= due_in[i];
      end
   end

`ifndef SYNTHESIS
   // armed flags and list length agree
   a_armed_count: assert property (@(posedge clock) disable iff (reset)
      $countones(armed_ff) == int'(o_count))
      else $error("armed flags disagree with list length");

   // never take a request while a word is offered
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request accepted while result pending");

   // an accepted last word returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not idle after final word");
`endif

endmodule
`default_nettype wire
